### rtl/core/pnpp_pkg.sv
`default_nettype none
package pnpp_pkg;

  localparam int unsigned RatioFracBitsDef = 16;
  localparam int unsigned SqIters          = 34;
  localparam int unsigned CoordW           = 32;
  localparam int unsigned LenW             = 48;
  localparam int unsigned DistW            = 34;
  localparam int unsigned OutDistW         = 33;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L2A,
    ST_L2B,
    ST_DOTA,
    ST_DOTB,
    ST_CHK,
    ST_DIV,
    ST_PX,
    ST_PY,
    ST_OFA,
    ST_OFB,
    ST_DSA,
    ST_DSB,
    ST_SQ,
    ST_UPD
  } state_e;

  typedef enum logic [1:0] {
    SQ_OFF,
    SQ_DIST,
    SQ_SEG
  } sq_phase_e;

endpackage
`default_nettype wire

### rtl/core/pnpp_if.sv
`default_nettype none
interface pnpp_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;
  logic               first_vertex;
  logic               last_vertex;

  modport source (output valid, vertex_x, vertex_y, query_x, query_y, first_vertex,
                  last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, query_x, query_y, first_vertex,
                last_vertex, output ready);
endinterface

interface pnpp_res_if;
  logic               valid;
  logic               ready;
  logic [32:0]        nearest_distance;
  logic [47:0]        along_offset;
  logic signed [31:0] projected_x;
  logic signed [31:0] projected_y;
  logic               found;

  modport source (output valid, nearest_distance, along_offset, projected_x, projected_y,
                  found, input ready);
  modport sink (input valid, nearest_distance, along_offset, projected_x, projected_y,
                found, output ready);
endinterface
`default_nettype wire

### rtl/core/polyline_nearest_point_projection.sv
// a vertex closing a segment passes the length, dot, check, divide, projection, offset,
//   root and update states; a clamped ratio skips the divide steps
// a new vertex is taken only in idle, so each segment finishes before the next is accepted
// the shared 33x33 multiplier, the divide steps and three 34-step roots set the segment time
// a waiting result stalls only the final update of the next polyline
// reset is asynchronous active low and idles control and best registers, not the datapath
`default_nettype none
module polyline_nearest_point_projection
  import pnpp_pkg::*;
#(
  parameter int unsigned RATIO_FRAC_BITS = RatioFracBitsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pnpp_vtx_if.sink    in_i,
  pnpp_res_if.source  out_o
);

  localparam int unsigned F     = RATIO_FRAC_BITS;
  localparam int unsigned MaxIt = (F > SqIters) ? F : SqIters;
  localparam int unsigned CntW  = $clog2(MaxIt + 1);

  state_e    state_q, state_d;
  sq_phase_e ph_q;

  logic signed [31:0] x1_q, y1_q, x2_q, y2_q, qx_q, qy_q, px_q, py_q;
  logic               have_prev_q, last_q, empty_q;
  logic [LenW-1:0]    run_len_q, best_off_q;
  logic [DistW-1:0]   best_dist_q;
  logic signed [31:0] best_px_q, best_py_q;
  logic               best_valid_q;

  logic [65:0]        l2_q, sum_q;
  logic signed [67:0] dot_q;
  logic [66:0]        rem_q;
  logic [F:0]         t_q;
  logic [CntW-1:0]    cnt_q;
  logic [67:0]        sqv_q;
  logic [36:0]        sqr_q;
  logic [33:0]        sqres_q;
  logic [33:0]        off_q, dist_q;

  logic               ov_q;
  logic [32:0]        o_dist_q;
  logic [47:0]        o_off_q;
  logic signed [31:0] o_px_q, o_py_q;
  logic               o_found_q;

  logic signed [32:0] dx, dy, ax, ay, ex, ey;
  logic [32:0]        mdx, mdy, max_, may, mex, mey;
  logic [32:0]        mul_a, mul_b;
  logic [65:0]        prod;
  logic               accept;
  logic               out_free;

  assign dx  = 33'(x2_q) - 33'(x1_q);
  assign dy  = 33'(y2_q) - 33'(y1_q);
  assign ax  = 33'(qx_q) - 33'(x1_q);
  assign ay  = 33'(qy_q) - 33'(y1_q);
  assign mdx = dx[32] ? 33'(-dx) : 33'(dx);
  assign mdy = dy[32] ? 33'(-dy) : 33'(dy);
  assign max_ = ax[32] ? 33'(-ax) : 33'(ax);
  assign may = ay[32] ? 33'(-ay) : 33'(ay);
  assign mex = ex[32] ? 33'(-ex) : 33'(ex);
  assign mey = ey[32] ? 33'(-ey) : 33'(ey);

  always_comb begin
    if (state_q == ST_OFA || state_q == ST_OFB) begin
      ex = 33'(px_q) - 33'(x1_q);
      ey = 33'(py_q) - 33'(y1_q);
    end else begin
      ex = 33'(px_q) - 33'(qx_q);
      ey = 33'(py_q) - 33'(qy_q);
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = mdx;
    mul_b = mdx;
    case (state_q)
      ST_L2A:  begin mul_a = mdx; mul_b = mdx; end
      ST_L2B:  begin mul_a = mdy; mul_b = mdy; end
      ST_DOTA: begin mul_a = max_; mul_b = mdx; end
      ST_DOTB: begin mul_a = may; mul_b = mdy; end
      ST_PX:   begin mul_a = mdx; mul_b = 33'(t_q[F-1:0]); end
      ST_PY:   begin mul_a = mdy; mul_b = 33'(t_q[F-1:0]); end
      ST_OFA, ST_DSA: begin mul_a = mex; mul_b = mex; end
      ST_OFB, ST_DSB: begin mul_a = mey; mul_b = mey; end
      default: begin mul_a = mdx; mul_b = mdx; end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !ov_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!in_i.first_vertex && have_prev_q) state_d = ST_L2A;
          else if (in_i.last_vertex) state_d = ST_UPD;
        end
      end
      ST_L2A:  state_d = ST_L2B;
      ST_L2B:  state_d = ST_DOTA;
      ST_DOTA: state_d = ST_DOTB;
      ST_DOTB: state_d = ST_CHK;
      ST_CHK: begin
        if (dot_q <= 0 || 68'(l2_q) <= dot_q) state_d = ST_PX;
        else state_d = ST_DIV;
      end
      ST_DIV:  if (cnt_q == CntW'(F - 1)) state_d = ST_PX;
      ST_PX:   state_d = ST_PY;
      ST_PY:   state_d = ST_OFA;
      ST_OFA:  state_d = ST_OFB;
      ST_OFB:  state_d = ST_SQ;
      ST_DSA:  state_d = ST_DSB;
      ST_DSB:  state_d = ST_SQ;
      ST_SQ: begin
        if (cnt_q == CntW'(SqIters - 1)) begin
          case (ph_q)
            SQ_OFF:  state_d = ST_DSA;
            SQ_DIST: state_d = ST_SQ;
            SQ_SEG:  state_d = ST_UPD;
            default: state_d = ST_UPD;
          endcase
        end
      end
      ST_UPD:  if (!last_q || out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // root step
  logic [36:0] sq_rem2, sq_trial;
  logic        sq_take;
  assign sq_rem2  = {sqr_q[34:0], sqv_q[67:66]};
  assign sq_trial = {1'b0, sqres_q, 2'b01};
  assign sq_take  = sq_rem2 >= sq_trial;

  // divide step
  logic [66:0] div_sh;
  logic        div_take;
  assign div_sh   = {rem_q[65:0], 1'b0};
  assign div_take = div_sh >= 67'(l2_q);

  // scaled projection
  logic [32:0] p_mag;
  logic signed [33:0] p_sum;
  always_comb begin
    p_mag = 33'(prod >> F);
    if (state_q == ST_PX) begin
      p_sum = dx[32] ? 34'(x1_q) - 34'(p_mag) : 34'(x1_q) + 34'(p_mag);
    end else begin
      p_sum = dy[32] ? 34'(y1_q) - 34'(p_mag) : 34'(y1_q) + 34'(p_mag);
    end
  end

  // best update
  logic               better;
  logic [LenW:0]      off_sum, len_sum;
  logic [LenW-1:0]    off_sat, len_sat;
  logic [DistW-1:0]   nb_dist;
  logic [LenW-1:0]    nb_off;
  logic signed [31:0] nb_px, nb_py;
  always_comb begin
    better  = dist_q < best_dist_q;
    off_sum = 49'(run_len_q) + 49'(off_q);
    len_sum = 49'(run_len_q) + 49'(sqres_q);
    off_sat = off_sum[LenW] ? '1 : off_sum[LenW-1:0];
    len_sat = len_sum[LenW] ? '1 : len_sum[LenW-1:0];
    nb_dist = better ? dist_q : best_dist_q;
    nb_off  = better ? off_sat : best_off_q;
    nb_px   = better ? px_q : best_px_q;
    nb_py   = better ? py_q : best_py_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0; y1_q <= '0; qx_q <= '0; qy_q <= '0;
      have_prev_q <= 1'b0; run_len_q <= '0;
      best_dist_q <= '1; best_off_q <= '1;
      best_px_q <= '0; best_py_q <= '0; best_valid_q <= 1'b0;
      ov_q <= 1'b0; ph_q <= SQ_OFF; cnt_q <= '0;
      last_q <= 1'b0; empty_q <= 1'b0;
    end else begin
      ov_q <= (state_q == ST_UPD && last_q && out_free) || (ov_q && !out_o.ready);
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            last_q  <= in_i.last_vertex;
            empty_q <= in_i.first_vertex || !have_prev_q;
            if (in_i.first_vertex || !have_prev_q) begin
              if (in_i.first_vertex) begin
                qx_q <= in_i.query_x;
                qy_q <= in_i.query_y;
              end
              x1_q <= in_i.vertex_x;
              y1_q <= in_i.vertex_y;
              x2_q <= in_i.vertex_x;
              y2_q <= in_i.vertex_y;
              have_prev_q  <= !in_i.last_vertex;
              run_len_q    <= '0;
              best_dist_q  <= '1;
              best_off_q   <= '1;
              best_px_q    <= '0;
              best_py_q    <= '0;
              best_valid_q <= 1'b0;
            end else begin
              x2_q   <= in_i.vertex_x;
              y2_q   <= in_i.vertex_y;
            end
          end
        end
        ST_L2A:  l2_q <= prod;
        ST_L2B:  l2_q <= l2_q + prod;
        ST_DOTA: dot_q <= (ax[32] ^ dx[32]) ? -68'(prod) : 68'(prod);
        ST_DOTB: dot_q <= (ay[32] ^ dy[32]) ? dot_q - 68'(prod) : dot_q + 68'(prod);
        ST_CHK: begin
          cnt_q <= '0;
          rem_q <= 67'(dot_q);
          if (dot_q <= 0) t_q <= '0;
          else if (68'(l2_q) <= dot_q) t_q <= (F+1)'(1) << F;
          else t_q <= '0;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          rem_q <= div_take ? div_sh - 67'(l2_q) : div_sh;
          t_q   <= {t_q[F-1:0], div_take};
        end
        ST_PX: px_q <= t_q[F] ? x2_q : p_sum[31:0];
        ST_PY: py_q <= t_q[F] ? y2_q : p_sum[31:0];
        ST_OFA, ST_DSA: sum_q <= prod;
        ST_OFB, ST_DSB: begin
          sqv_q   <= {2'b00, sum_q + prod};
          sqr_q   <= '0;
          sqres_q <= '0;
          cnt_q   <= '0;
          ph_q    <= (state_q == ST_OFB) ? SQ_OFF : SQ_DIST;
        end
        ST_SQ: begin
          if (cnt_q == CntW'(SqIters - 1)) begin
            cnt_q <= '0;
            sqr_q <= '0;
            case (ph_q)
              SQ_OFF: off_q <= {sqres_q[32:0], sq_take};
              SQ_DIST: begin
                dist_q  <= {sqres_q[32:0], sq_take};
                ph_q    <= SQ_SEG;
                sqv_q   <= {2'b00, l2_q};
                sqres_q <= '0;
              end
              default: sqres_q <= {sqres_q[32:0], sq_take};
            endcase
            if (ph_q != SQ_DIST && ph_q != SQ_SEG) sqres_q <= '0;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            sqv_q   <= {sqv_q[65:0], 2'b00};
            sqr_q   <= sq_take ? sq_rem2 - sq_trial : sq_rem2;
            sqres_q <= {sqres_q[32:0], sq_take};
          end
        end
        ST_UPD: begin
          if (!last_q || out_free) begin
            x1_q <= x2_q;
            y1_q <= y2_q;
            if (last_q) begin
              o_dist_q     <= empty_q ? '0 : nb_dist[32:0];
              o_off_q      <= empty_q ? '0 : nb_off;
              o_px_q       <= empty_q ? '0 : nb_px;
              o_py_q       <= empty_q ? '0 : nb_py;
              o_found_q    <= !empty_q;
              have_prev_q  <= 1'b0;
              run_len_q    <= '0;
              best_dist_q  <= '1;
              best_off_q   <= '1;
              best_px_q    <= '0;
              best_py_q    <= '0;
              best_valid_q <= 1'b0;
            end else begin
              best_dist_q  <= nb_dist;
              best_off_q   <= nb_off;
              best_px_q    <= nb_px;
              best_py_q    <= nb_py;
              best_valid_q <= 1'b1;
              run_len_q    <= len_sat;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_o.valid            = ov_q;
  assign out_o.nearest_distance = o_dist_q;
  assign out_o.along_offset     = o_off_q;
  assign out_o.projected_x      = o_px_q;
  assign out_o.projected_y      = o_py_q;
  assign out_o.found            = o_found_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> state_q == ST_IDLE)
    else $error("ready outside idle");
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !o_found_q) |-> (o_dist_q == '0 && o_off_q == '0))
    else $error("empty result not cleared");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> cnt_q < CntW'(F))
    else $error("divide overrun");
  a_upd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && (!last_q || out_free)) |=> state_q == ST_IDLE)
    else $error("update not followed by idle");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready) |=> ov_q)
    else $error("result dropped while stalled");

endmodule
`default_nettype wire

### tb/polyline_nearest_point_projection_test.sv
module polyline_nearest_point_projection_test;
  import pnpp_pkg::*;

  localparam int unsigned RATIO_BITS  = RatioFracBitsDef;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam longint      CMIN        = -64'sd2147483648;
  localparam longint      CMAX        = 64'sd2147483647;

  typedef struct {
    logic [32:0]        near_dist;
    logic [47:0]        offset;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               found;
  } nearest_t;

  class projection_scoreboard;
    nearest_t        pending[$];
    int              errors;
    longint          prev_x, prev_y, held_qx, held_qy, best_px, best_py;
    bit              have_prev, best_valid;
    logic [47:0]     run_len, best_off;
    logic [33:0]     best_dist;

    function new();
      errors = 0;
      prev_x = 0;
      prev_y = 0;
      held_qx = 0;
      held_qy = 0;
      clear_polyline();
    endfunction

    function void clear_polyline();
      have_prev  = 0;
      run_len    = '0;
      best_dist  = '1;
      best_off   = '1;
      best_px    = 0;
      best_py    = 0;
      best_valid = 0;
    endfunction

    function logic [127:0] sum_sq(longint a, longint b);
      logic signed [127:0] wa, wb;
      wa = a;
      wb = b;
      return wa * wa + wb * wb;
    endfunction

    function logic [63:0] floor_sqrt(logic [127:0] v);
      logic [127:0] c;
      logic [63:0]  r;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= v) r = c[63:0];
      end
      return r;
    endfunction

    function logic [47:0] add_sat(logic [47:0] a, logic [63:0] b);
      logic [64:0] s;
      s = a + b;
      return (s > 65'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    function longint scale_delta(longint d, logic [63:0] t);
      logic [127:0] p;
      longint       m;
      if (t >= (64'd1 << RATIO_BITS)) return d;
      m = (d < 0) ? -d : d;
      p = (m * t) >> RATIO_BITS;
      return (d < 0) ? -longint'(p) : longint'(p);
    endfunction

    function void segment(longint x2, longint y2);
      longint              dx, dy, ax, ay, px, py;
      logic [127:0]        l2;
      logic signed [127:0] dot, wl2;
      logic [63:0]         seg_len, qdist, off, t;
      dx = x2 - prev_x;
      dy = y2 - prev_y;
      ax = held_qx - prev_x;
      ay = held_qy - prev_y;
      l2 = sum_sq(dx, dy);
      seg_len = floor_sqrt(l2);
      if (l2 == 0) begin
        qdist = floor_sqrt(sum_sq(ax, ay));
        off   = 0;
        px    = prev_x;
        py    = prev_y;
      end else begin
        dot = 128'(signed'(ax)) * 128'(signed'(dx)) + 128'(signed'(ay)) * 128'(signed'(dy));
        wl2 = l2;
        if (dot <= 0) t = 0;
        else if (dot >= wl2) t = 64'd1 << RATIO_BITS;
        else t = 64'((128'(dot) << RATIO_BITS) / l2);
        px    = prev_x + scale_delta(dx, t);
        py    = prev_y + scale_delta(dy, t);
        off   = floor_sqrt(sum_sq(px - prev_x, py - prev_y));
        qdist = floor_sqrt(sum_sq(px - held_qx, py - held_qy));
      end
      if (qdist < best_dist) begin
        best_dist = qdist[33:0];
        best_off  = add_sat(run_len, off);
        best_px   = px;
        best_py   = py;
      end
      best_valid = 1;
      run_len = add_sat(run_len, seg_len);
    endfunction

    function void note_request(longint vx, longint vy, longint qx, longint qy,
                               bit first, bit last);
      nearest_t r;
      if (first) begin
        held_qx = qx;
        held_qy = qy;
        clear_polyline();
      end else if (have_prev) begin
        segment(vx, vy);
      end
      prev_x = vx;
      prev_y = vy;
      have_prev = 1;
      if (last) begin
        if (best_valid) begin
          r.near_dist = best_dist[32:0];
          r.offset    = best_off;
          r.px        = best_px[31:0];
          r.py        = best_py[31:0];
          r.found     = 1;
        end else begin
          r = '{default: '0};
        end
        pending = {pending, r};
        clear_polyline();
      end
    endfunction

    function void check_result(nearest_t act);
      nearest_t e;
      if (pending.size() == 0) begin
        $error("unexpected result nearest_distance=%0d", act.near_dist);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (act.near_dist !== e.near_dist) begin
        $error("nearest_distance exp %0d got %0d", e.near_dist, act.near_dist);
        errors++;
      end
      if (act.offset !== e.offset) begin
        $error("along_offset exp %0d got %0d", e.offset, act.offset);
        errors++;
      end
      if (act.px !== e.px) begin
        $error("projected_x exp %0d got %0d", e.px, act.px);
        errors++;
      end
      if (act.py !== e.py) begin
        $error("projected_y exp %0d got %0d", e.py, act.py);
        errors++;
      end
      if (act.found !== e.found) begin
        $error("found exp %0d got %0d", e.found, act.found);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni;
  int   cycles = 0;
  int   tx_idle = 0;
  int   rx_idle = 0;
  bit   hold_req = 0;
  bit   hold_done = 0;
  int   hold_left = 0;
  projection_scoreboard sb = new();

  pnpp_vtx_if vtx ();
  pnpp_res_if res ();

  polyline_nearest_point_projection DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (vtx),
    .out_o (res)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("polyline_nearest_point_projection: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && vtx.valid && vtx.ready)
      sb.note_request(vtx.vertex_x, vtx.vertex_y, vtx.query_x, vtx.query_y,
                      vtx.first_vertex, vtx.last_vertex);
    if (rst_ni && res.valid && res.ready)
      sb.check_result('{res.nearest_distance, res.along_offset, res.projected_x,
                        res.projected_y, res.found});
  end

  task automatic send_vertex(longint vx, longint vy, longint qx, longint qy,
                             bit first, bit last);
    while ($urandom_range(0, 99) < tx_idle) begin
      vtx.valid <= 1'b0;
      @(posedge clk_i);
    end
    vtx.valid        <= 1'b1;
    vtx.vertex_x     <= vx[31:0];
    vtx.vertex_y     <= vy[31:0];
    vtx.query_x      <= qx[31:0];
    vtx.query_y      <= qy[31:0];
    vtx.first_vertex <= first;
    vtx.last_vertex  <= last;
    do @(posedge clk_i); while (!(vtx.ready === 1'b1));
  endtask

  function automatic longint rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return longint'($urandom_range(0, 8000)) - 4000;
      4, 5, 6:    return longint'($urandom_range(0, 2000000)) - 1000000;
      7:          return $urandom_range(0, 1) ? CMAX - $urandom_range(0, 3)
                                              : CMIN + $urandom_range(0, 3);
      default:    return longint'(signed'($urandom()));
    endcase
  endfunction

  task automatic random_polylines(int n_items);
    int     sent, len;
    longint vx, vy;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    $urandom_range(0, 1), $urandom_range(0, 1));
        sent++;
      end else begin
        len = $urandom_range(1, 8);
        vx = rand_coord();
        vy = rand_coord();
        for (int i = 0; i < len; i++) begin
          if (i > 0 && $urandom_range(0, 7) == 0) begin
            // repeated vertex gives a zero-length segment
          end else if (i > 0 && $urandom_range(0, 1) == 0) begin
            vx = vx + longint'($urandom_range(0, 4000)) - 2000;
            vy = vy + longint'($urandom_range(0, 4000)) - 2000;
            if (vx > CMAX) vx = CMAX;
            if (vx < CMIN) vx = CMIN;
            if (vy > CMAX) vy = CMAX;
            if (vy < CMIN) vy = CMIN;
          end else if (i > 0) begin
            vx = rand_coord();
            vy = rand_coord();
          end
          send_vertex(vx, vy, vx + longint'($urandom_range(0, 6000)) - 3000 > CMAX ? CMAX
                      : rand_coord(), rand_coord(), i == 0, i == len - 1);
          sent++;
        end
      end
    end
  endtask

  task automatic drain();
    vtx.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    vtx.valid = 0;
    vtx.vertex_x = 0;
    vtx.vertex_y = 0;
    vtx.query_x = 0;
    vtx.query_y = 0;
    vtx.first_vertex = 0;
    vtx.last_vertex = 0;
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    tx_idle = 37;
    rx_idle = 70;
    // single vertex, and an unmarked vertex opening and closing a polyline
    send_vertex(CMIN, CMAX, CMAX, CMIN, 1, 1);
    send_vertex(5, 7, 0, 0, 0, 1);
    // zero-length segment in the middle
    send_vertex(0, 0, 100, 100, 1, 0);
    send_vertex(1000, 0, 0, 0, 0, 0);
    send_vertex(1000, 0, 0, 0, 0, 0);
    send_vertex(1000, 1000, 0, 0, 0, 1);
    // ratio clamped low and high
    send_vertex(0, 0, -500, -500, 1, 0);
    send_vertex(256, 0, 0, 0, 0, 1);
    send_vertex(0, 0, 5000, 3, 1, 0);
    send_vertex(256, 0, 0, 0, 0, 1);
    // restart mark drops the open polyline
    send_vertex(0, 0, 9, 9, 1, 0);
    send_vertex(10, 10, 0, 0, 0, 0);
    send_vertex(5, 5, 40, -30, 1, 0);
    send_vertex(50, 5, 0, 0, 0, 1);
    // coordinate extremes
    send_vertex(CMIN, CMIN, CMAX, CMAX, 1, 0);
    send_vertex(CMAX, CMAX, 0, 0, 0, 0);
    send_vertex(CMAX, CMIN, 0, 0, 0, 1);
    // equal distances, earliest segment wins
    send_vertex(-256, 0, 0, 256, 1, 0);
    send_vertex(0, 0, 0, 0, 0, 0);
    send_vertex(256, 0, 0, 0, 0, 1);
    // unmarked start keeps the held query point
    send_vertex(-300, 40, 77, 77, 0, 0);
    send_vertex(300, 40, 77, 77, 0, 1);
    random_polylines(500);
    drain();

    tx_idle = 70;
    rx_idle = 37;
    random_polylines(530);
    drain();

    tx_idle = 0;
    rx_idle = 0;
    hold_req = 1;
    random_polylines(550);
    drain();

    if (sb.errors == 0) begin
      $display("polyline_nearest_point_projection: match");
    end else begin
      $display("polyline_nearest_point_projection: mismatch");
    end
    $finish;
  end

endmodule
